/* rtl/assert_macros.svh */
// assertion macros used by the rtl top level to check its own logic
// no dependencies; each macro takes a label, clock, active-low reset and a message
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rss_pkg.sv */
// types, constants and helpers for the raid0 stripe splitter
// no dependencies; used by every rtl module of the block
`default_nettype none

package rss_pkg;

  // fixed limits of the stripe set
  localparam int unsigned MaxChunks    = 16;
  localparam int unsigned MaxXferBytes = 65536;
  localparam int unsigned StripShiftMin = 12;
  localparam int unsigned StripShiftMax = 20;

  // datapath widths
  localparam int unsigned LbaW     = 49;                // byte address of the request
  localparam int unsigned DivSteps = (LbaW - StripShiftMin + 1) / 2;
  localparam int unsigned DivW     = 2 * DivSteps;      // strip number, padded to radix 4
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  localparam int unsigned SizeW    = StripShiftMax + 1; // strip size in bytes
  localparam int unsigned SoffW    = StripShiftMax;     // offset within a strip
  localparam int unsigned PhysW    = 50;                // member byte address

  // register map
  typedef enum logic [1:0] {
    RegStripShift = 2'd0,
    RegChunkCount = 2'd1,
    RegOnlineMask = 2'd2,
    RegDataOffset = 2'd3
  } reg_addr_e;

  typedef struct packed {
    logic [39:0] start_block;
    logic [16:0] transfer_bytes;
    logic        is_write;
  } req_t;

  typedef struct packed {
    logic [3:0]  chunk_index;
    logic [39:0] phys_block;
    logic [16:0] piece_bytes;
    logic [15:0] buffer_offset;
    logic        piece_write;
    logic        chunk_offline;
    logic        last_piece;
  } res_t;

  // effective configuration after saturation
  typedef struct packed {
    logic [4:0]  shift;
    logic [4:0]  count;
    logic [15:0] online;
    logic [19:0] doff;
  } cfg_t;

  typedef enum logic [1:0] {
    StIdle,
    StDivide,
    StSetup,
    StEmit
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic setup;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic piece_last;
  } ctrl_sts_t;

  function automatic logic [4:0] sat_shift(logic [4:0] raw);
    logic [4:0] v;
    v = raw;
    if (raw < 5'(StripShiftMin)) v = 5'(StripShiftMin);
    if (raw > 5'(StripShiftMax)) v = 5'(StripShiftMax);
    return v;
  endfunction

  function automatic logic [4:0] sat_count(logic [4:0] raw);
    logic [4:0] v;
    v = raw;
    if (raw < 5'd2) v = 5'd2;
    if (raw > 5'(MaxChunks)) v = 5'(MaxChunks);
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/raid0_stripe_splitter_unit.sv */
// top level of the raid0 stripe splitter: config registers, sequencer, datapath
// depends on rss_pkg, rss_ctrl, rss_datapath and assert_macros.svh
//
// usage
//   a request (start block, byte length, direction) is taken on req_i at a clock
//   edge where start is high and busy is low. it is split into per-disk pieces,
//   each shown on result_o with result_strobe_o high for exactly one cycle; the
//   receiver cannot stall, so every strobe is a delivered item. the final item
//   of a request has last_piece set; an offline chunk ends the request with one
//   item that has chunk_offline and last_piece set.
//   the strip number is divided by the chunk count two bits per cycle, a setup
//   step follows, then one piece per cycle is registered onto result_o; a
//   request yields 1 to 17 pieces, and a new request is taken only once its
//   last piece has been emitted; busy is high meanwhile. the user must see
//   that configuration is written over the apb port only while no request is
//   open; the block itself does not enforce this.
//   reset clears the sequencer, the result strobe and the registers to their
//   defaults: strip shift 16, chunk count 2, no chunk online, data offset 0.
`default_nettype none
`include "assert_macros.svh"

module raid0_stripe_splitter_unit
  import rss_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // command channel
  input  wire logic        start,
  output logic             busy,
  input  wire req_t        req_i,
  // results
  output res_t             result_o,
  output logic             result_strobe_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [4:0]  strip_shift_q;
  logic [4:0]  chunk_count_q;
  logic [15:0] online_mask_q;
  logic [19:0] data_offset_q;
  logic        cfg_wr;
  reg_addr_e   reg_sel;
  cfg_t        cfg;
  ctrl_cmd_t   cmd;
  ctrl_sts_t   sts;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_addr_e'(paddr[3:2]);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_shift_q <= 5'd16;
      chunk_count_q <= 5'd2;
      online_mask_q <= '0;
      data_offset_q <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        RegStripShift: strip_shift_q <= pwdata[4:0];
        RegChunkCount: chunk_count_q <= pwdata[4:0];
        RegOnlineMask: online_mask_q <= pwdata[15:0];
        RegDataOffset: data_offset_q <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      RegStripShift: prdata = 32'(strip_shift_q);
      RegChunkCount: prdata = 32'(chunk_count_q);
      RegOnlineMask: prdata = 32'(online_mask_q);
      RegDataOffset: prdata = 32'(data_offset_q);
      default:       prdata = '0;
    endcase
  end

  // effective configuration
  always_comb begin
    cfg.shift  = sat_shift(strip_shift_q);
    cfg.count  = sat_count(chunk_count_q);
    cfg.online = online_mask_q;
    cfg.doff   = data_offset_q;
  end

  rss_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  rss_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .req_i           (req_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .result_o        (result_o),
    .result_strobe_o (result_strobe_o)
  );

  // checks on the block's own sequencing
  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accepted item did not raise busy")
  `ASSERT_IMPLIES(a_strobe_emit, clk_i, rst_ni, result_strobe_o, $past(cmd.emit), "result without emit step")
  `ASSERT_IMPLIES(a_offline_last, clk_i, rst_ni, result_strobe_o && result_o.chunk_offline, result_o.last_piece, "offline item not last")
  `ASSERT_IMPLIES(a_chunk_range, clk_i, rst_ni, result_strobe_o, 5'(result_o.chunk_index) < cfg.count, "chunk index beyond chunk count")

endmodule

`default_nettype wire

/* rtl/rss_ctrl.sv */
// sequencer of the stripe splitter: divide, setup, then one piece per cycle
// depends on rss_pkg
`default_nettype none

module rss_ctrl
  import rss_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t      cmd_o
);

  ctrl_state_e        state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;

  // state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          cnt_d      = DivCntW'(DivSteps - 1);
          state_d    = StDivide;
        end
      end
      StDivide: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = StSetup;
        end else begin
          cnt_d = cnt_q - DivCntW'(1);
        end
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
        state_d     = StEmit;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        if (sts_i.piece_last) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy = (state_q != StIdle);

endmodule

`default_nettype wire

/* rtl/rss_datapath.sv */
// datapath of the stripe splitter: strip divider, address walk, result register
// depends on rss_pkg
`default_nettype none

module rss_datapath
  import rss_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire req_t      req_i,
  input  wire ctrl_cmd_t cmd_i,
  output ctrl_sts_t      sts_o,
  output res_t           result_o,
  output logic           result_strobe_o
);

  logic [DivW-1:0]  div_q, div_d;
  logic [3:0]       rem_q, rem_d;
  logic [SoffW-1:0] soff_q;
  logic [16:0]      left_q;
  logic [16:0]      len_q;
  logic [15:0]      buf_q;
  logic [3:0]       chunk_q;
  logic [PhysW-1:0] phys_q;
  logic             first_q;
  logic             wr_q;
  res_t             res_q, res_d;
  logic             strobe_q;

  logic [LbaW-1:0]  lba;
  logic [LbaW-1:0]  strip_full;
  logic [SoffW-1:0] soff_mask;
  logic [SoffW-1:0] soff_new;
  logic [16:0]      left_new;
  logic [SizeW-1:0] size;
  logic [SizeW-1:0] room;
  logic [16:0]      first_len;
  logic [PhysW-1:0] phys_base;
  logic             online;
  logic [16:0]      left_nx;
  logic             done;
  logic             wrap;
  logic [PhysW-1:0] phys_add;
  logic [16:0]      next_len;

  // request decode at load
  always_comb begin
    lba        = {req_i.start_block, 9'd0};
    strip_full = lba >> cfg_i.shift;
    soff_mask  = ~(SoffW'({SoffW{1'b1}}) << cfg_i.shift);
    soff_new   = lba[SoffW-1:0] & soff_mask;
    if (req_i.transfer_bytes > 17'(MaxXferBytes)) begin
      left_new = 17'(MaxXferBytes);
    end else begin
      left_new = req_i.transfer_bytes;
    end
  end

  // two restoring-division steps per cycle: strip number by chunk count
  always_comb begin
    logic [4:0]      t;
    logic [3:0]      r;
    logic [DivW-1:0] q;
    r = rem_q;
    q = div_q;
    for (int i = 0; i < 2; i++) begin
      t = {r, q[DivW-1]};
      q = {q[DivW-2:0], 1'b0};
      if (t >= cfg_i.count) begin
        t    = t - cfg_i.count;
        q[0] = 1'b1;
      end
      r = t[3:0];
    end
    div_d = q;
    rem_d = r;
  end

  // first piece: member address and length up to the strip end
  always_comb begin
    size      = SizeW'(1) << cfg_i.shift;
    room      = size - SizeW'(soff_q);
    first_len = (SizeW'(left_q) < room) ? left_q : room[16:0];
    phys_base = ((PhysW'(div_q) << cfg_i.shift) | PhysW'(soff_q))
              + PhysW'({cfg_i.doff, 9'd0});
  end

  // piece emit: result, remaining bytes and walk to the next chunk
  always_comb begin
    online  = cfg_i.online[chunk_q];
    left_nx = left_q - len_q;
    done    = !online || (left_nx == '0);
    wrap    = (5'(chunk_q) + 5'd1) >= cfg_i.count;
    if (wrap) begin
      phys_add = PhysW'(len_q);
    end else if (first_q) begin
      phys_add = PhysW'(0) - PhysW'(soff_q);
    end else begin
      phys_add = '0;
    end
    next_len = (SizeW'(left_nx) < size) ? left_nx : size[16:0];
    res_d.chunk_index = chunk_q;
    res_d.piece_write = wr_q;
    res_d.last_piece  = done;
    if (online) begin
      res_d.phys_block    = phys_q[48:9];
      res_d.piece_bytes   = len_q;
      res_d.buffer_offset = buf_q;
      res_d.chunk_offline = 1'b0;
    end else begin
      res_d.phys_block    = '0;
      res_d.piece_bytes   = '0;
      res_d.buffer_offset = '0;
      res_d.chunk_offline = 1'b1;
    end
  end

  assign sts_o.piece_last = done;

  // working registers of the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      div_q  <= strip_full[DivW-1:0];
      rem_q  <= '0;
      soff_q <= soff_new;
      left_q <= left_new;
      buf_q  <= '0;
      wr_q   <= req_i.is_write;
    end
    if (cmd_i.div_step) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end
    if (cmd_i.setup) begin
      phys_q  <= phys_base;
      chunk_q <= rem_q;
      len_q   <= first_len;
      first_q <= 1'b1;
    end
    if (cmd_i.emit) begin
      left_q  <= left_nx;
      buf_q   <= buf_q + len_q[15:0];
      chunk_q <= wrap ? 4'd0 : chunk_q + 4'd1;
      phys_q  <= phys_q + phys_add;
      len_q   <= next_len;
      first_q <= 1'b0;
      res_q   <= res_d;
    end
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
    end
  end

  assign result_o        = res_q;
  assign result_strobe_o = strobe_q;

endmodule

`default_nettype wire
